[hdl/stlb_pkg.sv]
// Shared definitions for the sorted table lower-bound core.
// Holds the default table depth, field widths and command codes.
// No dependencies.
package stlb_pkg;

  // Default number of table entries.
  localparam int DEPTH_DEFAULT = 64;

  // Width of one table element and of the value field.
  localparam int VAL_W = 32;

  // Width of the position and entry_count result fields.
  localparam int OUT_W = 7;

  // Command codes carried on the command field.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

endpackage

[hdl/stlb_ram.sv]
// Table storage for the sorted table lower-bound core.
// One write port and one read port with registered read data.
// Depends on stlb_pkg for the element width.
module stlb_ram
  import stlb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic signed [VAL_W-1:0]                wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic signed [VAL_W-1:0]                rd_data
);

  logic signed [VAL_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/sorted_table_lower_bound_core.sv]
// Sorted table of signed 32-bit values with clear, append and lower-bound query.
// A query finds the first entry at or above the target by binary search, and an
// append searches for the first entry above the value and then moves the upper
// entries up one place, each by a read in S_SHIFT and a write in S_MOVE, through
// a single memory read port and write port. Each step of the search is one
// memory read (S_PROBE) followed by one compare (S_CHECK). A command beat is
// taken when start is high and busy is low. A clear, an unused command code or
// an append to a full table is answered from idle, with done in the next cycle.
// Each result beat stands on the result ports for exactly one cycle, marked by
// done, and must be taken then: the receiver cannot hold it off.
// Depends on stlb_pkg and stlb_ram.
module sorted_table_lower_bound_core
  import stlb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              command,
  input  logic signed [VAL_W-1:0] value,
  output logic                    done,
  output logic                    status,
  output logic [OUT_W-1:0]        position,
  output logic                    none_found,
  output logic [OUT_W-1:0]        entry_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CHECK,
    S_SHIFT,
    S_MOVE
  } state_t;

  state_t                  state;
  logic [CW-1:0]           count;
  logic [CW-1:0]           lo;
  logic [CW-1:0]           hi;
  logic [CW-1:0]           mid;
  logic [CW-1:0]           idx;
  logic signed [VAL_W-1:0] key;
  logic                    is_append;

  logic [CW-1:0]           mid_next;
  logic                    hit;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [VAL_W-1:0] wr_data;
  logic [AW-1:0]           rd_addr;
  logic signed [VAL_W-1:0] rd_data;

  // Midpoint of the open search interval.
  assign mid_next = lo + ((hi - lo) >> 1);

  // Appends look for the first entry above the value, queries for the first not below.
  assign hit = is_append ? (rd_data > key) : (rd_data >= key);

  // Memory port control: moves during the shift, the new value at the end.
  always_comb begin
    rd_addr = (state == S_SHIFT) ? AW'(idx - CW'(1)) : AW'(mid_next);
    wr_en   = (state == S_MOVE) || ((state == S_SHIFT) && (idx == lo));
    wr_addr = (state == S_MOVE) ? AW'(idx) : AW'(lo);
    wr_data = (state == S_MOVE) ? rd_data : key;
  end

  stlb_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy        = (state != S_IDLE);
  assign entry_count = OUT_W'(count);

  // Sequencer with its registered result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      done       <= 1'b0;
      status     <= 1'b0;
      position   <= '0;
      none_found <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            key        <= value;
            is_append  <= (command == CMD_APPEND);
            lo         <= '0;
            hi         <= count;
            status     <= 1'b0;
            position   <= '0;
            none_found <= 1'b0;
            priority if (command == CMD_CLEAR) begin
              count <= '0;
              done  <= 1'b1;
            end else if ((command == CMD_APPEND) && (count >= CW'(DEPTH))) begin
              status <= 1'b1;
              done   <= 1'b1;
            end else if ((command == CMD_APPEND) || (command == CMD_QUERY)) begin
              state <= S_PROBE;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_PROBE: begin
          if (lo < hi) begin
            mid   <= mid_next;
            state <= S_CHECK;
          end else if (is_append) begin
            idx   <= count;
            state <= S_SHIFT;
          end else begin
            position   <= OUT_W'(lo);
            none_found <= (lo == count);
            done       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_CHECK: begin
          if (hit) begin
            hi <= mid;
          end else begin
            lo <= mid + CW'(1);
          end
          state <= S_PROBE;
        end
        S_SHIFT: begin
          if (idx > lo) begin
            state <= S_MOVE;
          end else begin
            count <= count + CW'(1);
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_MOVE: begin
          idx   <= idx - CW'(1);
          state <= S_SHIFT;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The entry count never exceeds the table depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above table depth");

  // The search interval stays ordered and within the held entries.
  a_interval: assert property (@(posedge clk) disable iff (rst)
    ((state == S_PROBE) || (state == S_CHECK)) |-> ((lo <= hi) && (hi <= count)))
    else $error("search interval out of order");

  // The shift never runs below the insertion point.
  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SHIFT) || (state == S_MOVE)) |-> (idx >= lo))
    else $error("shift index below insertion point");

  // A result beat only appears once the sequencer is back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  // An accepted command either finishes at once or keeps the block busy.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command was lost");

endmodule

[dv/sorted_table_lower_bound_core_test.sv]
// Testbench for the sorted table lower-bound core: drives clear, append, query
// and unused command beats, predicts every result from a shadow copy of the
// table and checks each done beat in order. Depends on stlb_pkg and the core.
`timescale 1ns / 100ps

module sorted_table_lower_bound_core_test;
  import stlb_pkg::*;

  // Command code that the core must treat as a no-op.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  // Cycles without any beat before the run is declared hung.
  localparam int QUIET_LIMIT = 4000;
  // Cycles to watch for stray results once nothing is expected.
  localparam int TAIL_CYCLES = 200;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic             status;
    logic [OUT_W-1:0] position;
    logic             none_found;
    logic [OUT_W-1:0] entry_count;
  } table_result_t;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [1:0]              command;
  logic signed [VAL_W-1:0] value;
  logic                    done;
  logic                    status;
  logic [OUT_W-1:0]        position;
  logic                    none_found;
  logic [OUT_W-1:0]        entry_count;

  // Shadow copy of the table, kept in ascending order.
  logic signed [VAL_W-1:0] shadow_table[$];
  table_result_t           pending_results[$];
  int                      mismatches;
  int                      idle_pct;
  int                      quiet_cycles;

  sorted_table_lower_bound_core u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .value       (value),
    .done        (done),
    .status      (status),
    .position    (position),
    .none_found  (none_found),
    .entry_count (entry_count)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Apply one command to the shadow table and return the result it should give.
  function automatic table_result_t predict_table_result(input logic [1:0] cmd,
                                                        input logic signed [VAL_W-1:0] val);
    table_result_t r;
    int            at;
    r = '0;
    at = 0;
    case (cmd)
      CMD_CLEAR: begin
        shadow_table.delete();
      end
      CMD_APPEND: begin
        if (shadow_table.size() >= DEPTH_DEFAULT) begin
          r.status = 1'b1;
        end else begin
          // Insert after any equal entries so duplicates stay in order.
          while (at < shadow_table.size() && shadow_table[at] <= val) at++;
          shadow_table.insert(at, val);
        end
      end
      CMD_QUERY: begin
        while (at < shadow_table.size() && shadow_table[at] < val) at++;
        r.position   = OUT_W'(at);
        r.none_found = (at == shadow_table.size());
      end
      default: begin
      end
    endcase
    r.entry_count = OUT_W'(shadow_table.size());
    return r;
  endfunction

  // Values lean toward small numbers, extremes and neighbors of held entries,
  // so duplicates and exact hits are common.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int sel;
    int offset;
    sel = $urandom_range(99);
    offset = int'($urandom_range(2)) - 1;
    if (sel < 25) begin
      return int'($urandom_range(8)) - 4;
    end else if (sel < 37) begin
      case ($urandom_range(3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return '0;
        default: return -1;
      endcase
    end else if (sel < 62 && shadow_table.size() != 0) begin
      return shadow_table[$urandom_range(shadow_table.size() - 1)] + offset;
    end
    return $urandom;
  endfunction

  // Send one command beat, with random idle cycles ahead of it.
  task automatic send_command(input logic [1:0] cmd, input logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    command <= cmd;
    value   <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_table_result(cmd, val));
  endtask

  // Empty table, extremes, duplicates and the unused command code.
  task automatic test_directed_cases();
    send_command(CMD_CLEAR, '0);
    send_command(CMD_QUERY, VAL_MIN);
    send_command(CMD_QUERY, VAL_MAX);
    send_command(CMD_UNUSED, VAL_MAX);
    send_command(CMD_APPEND, 0);
    send_command(CMD_APPEND, VAL_MAX);
    send_command(CMD_APPEND, VAL_MIN);
    send_command(CMD_APPEND, -1);
    send_command(CMD_APPEND, 5);
    send_command(CMD_APPEND, 5);
    send_command(CMD_APPEND, 5);
    send_command(CMD_QUERY, 5);
    send_command(CMD_QUERY, 6);
    send_command(CMD_QUERY, 4);
    send_command(CMD_QUERY, VAL_MIN);
    send_command(CMD_QUERY, VAL_MAX);
    send_command(CMD_QUERY, -1);
    send_command(CMD_UNUSED, VAL_MIN);
    send_command(CMD_APPEND, VAL_MAX);
    send_command(CMD_QUERY, VAL_MAX);
    send_command(CMD_CLEAR, VAL_MAX);
    send_command(CMD_QUERY, 0);
  endtask

  // Fill the table to the top, then push appends against the full table.
  task automatic test_fill_to_full();
    send_command(CMD_CLEAR, pick_value());
    repeat (DEPTH_DEFAULT) send_command(CMD_APPEND, pick_value());
    repeat (3) send_command(CMD_APPEND, pick_value());
    repeat (6) send_command(CMD_QUERY, pick_value());
    send_command(CMD_QUERY, VAL_MAX);
    send_command(CMD_QUERY, VAL_MIN);
    send_command(CMD_UNUSED, pick_value());
  endtask

  // Mixed traffic; appends outnumber clears so the table grows deep.
  task automatic test_random_traffic(input int beats);
    int roll;
    repeat (beats) begin
      roll = $urandom_range(99);
      if (roll < 3)       send_command(CMD_CLEAR, pick_value());
      else if (roll < 7)  send_command(CMD_UNUSED, pick_value());
      else if (roll < 52) send_command(CMD_APPEND, pick_value());
      else                send_command(CMD_QUERY, pick_value());
    end
  endtask

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    table_result_t got;
    table_result_t want;
    if (!rst && done) begin
      got = '{status, position, none_found, entry_count};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: status %0d position %0d none_found %0d count %0d",
                   got.status, got.position, got.none_found, got.entry_count);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result mismatch: status %0d/%0d position %0d/%0d none_found %0d/%0d count %0d/%0d (exp/got)",
                     want.status, got.status, want.position, got.position,
                     want.none_found, got.none_found, want.entry_count, got.entry_count);
        end
      end
    end
  end

  // Watchdog on cycles in which no beat moves in either direction.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("sorted_table_lower_bound_core test failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    command = CMD_CLEAR;
    value = '0;
    idle_pct = 0;
    mismatches = 0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    idle_pct = 0;
    test_random_traffic(220);
    idle_pct = 65;
    test_random_traffic(160);
    idle_pct = 30;
    test_fill_to_full();
    test_random_traffic(140);
    start <= 1'b0;

    // Let outstanding results arrive, then watch for any stray ones.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("sorted_table_lower_bound_core test passed");
    end else begin
      $display("sorted_table_lower_bound_core test failed");
    end
    $finish;
  end

endmodule
